>>> rtl/hpt_pkg.sv
// Shared types, constants and register codes of the HSV pixel tint block.
`timescale 1ns / 1ps

package hpt_pkg;

    localparam int unsigned ChanW    = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 13;
    localparam int unsigned HueW     = 13;
    localparam int unsigned SatW     = 9;
    localparam int unsigned GainW    = 10;
    localparam int unsigned FracW    = 10;

    localparam int unsigned OneS      = 256;
    localparam int unsigned HueSector = 960;
    localparam int unsigned HueFull   = 5760;
    localparam int unsigned FracOne   = OneS * HueSector;

    // register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_HUE_KEEP = 3'd0,
        CFG_HUE      = 3'd1,
        CFG_SAT      = 3'd2,
        CFG_GAIN     = 3'd3
    } t_cfg_idx;

    // hue sectors, named by the two primaries/secondaries they span
    typedef enum logic [2:0] {
        SECT_R_Y = 3'd0,
        SECT_Y_G = 3'd1,
        SECT_G_C = 3'd2,
        SECT_C_B = 3'd3,
        SECT_B_M = 3'd4,
        SECT_M_R = 3'd5
    } t_sector;

    // live settings plus coefficients derived from them
    typedef struct packed {
        logic                 hue_keep;
        logic [SatW-1:0]      sat;
        logic [GainW-1:0]     gain;
        t_sector              sector;
        logic signed [9:0]    kp;   // 256 - s
        logic signed [19:0]   kq;   // 245760 - s*f
        logic signed [19:0]   kt;   // 245760 - s*(960-f)
    } t_coef;

endpackage

>>> rtl/hpt_ifs.sv
// Pixel stream interfaces: input beat and output beat channels.
`timescale 1ns / 1ps

interface hpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface hpt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, output ready);
endinterface

>>> rtl/hsv_pixel_tint_unit.sv
// HSV pixel tint top level: five-stage pixel pipeline with configuration block.
// An accepted beat moves through stages 1 to 5 in order; stage 5 drives the output.
// Throughput: one pixel per clock; each stage holds one pixel and moves when the next
// stage is empty or moving, so bubbles close up while the output waits.
// Reset: synchronous active-low; clears all stage valid bits and loads register defaults.
`timescale 1ns / 1ps

module hsv_pixel_tint_unit
    import hpt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    hpt_in_if.sink              i_pix,
    hpt_out_if.source           o_pix
);

    // reciprocal constants: x/3 = (x*683)>>11 for x <= 765, y/15 = (y*34953)>>19 for
    // y < 4096
    localparam int unsigned AvgRecip = 683;
    localparam int unsigned AvgShift = 11;
    localparam int unsigned R15Recip = 34953;
    localparam int unsigned R15Shift = 19;

    t_coef coef;

    hpt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (coef)
    );

    // ---------------------------------------------------------------
    // stage enables: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_vld5 || o_pix.ready;
    assign en4 = !r_vld4 || en5;
    assign en3 = !r_vld3 || en4;
    assign en2 = !r_vld2 || en3;
    assign en1 = !r_vld1 || en2;

    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_pix.valid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
            if (en4) r_vld4 <= r_vld3;
            if (en5) r_vld5 <= r_vld4;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: input register
    // ---------------------------------------------------------------
    logic [ChanW-1:0] r_red1, r_green1, r_blue1, r_alpha1;

    always_ff @(posedge i_clk) begin
        if (en1 && i_pix.valid) begin
            r_red1   <= i_pix.red_in;
            r_green1 <= i_pix.green_in;
            r_blue1  <= i_pix.blue_in;
            r_alpha1 <= i_pix.alpha_in;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: gray level, sum / 3 by reciprocal multiply
    // ---------------------------------------------------------------
    logic [9:0]       sum1;
    logic [19:0]      avg_prod1;
    logic [ChanW-1:0] n_avg;

    assign sum1      = 10'(r_red1) + 10'(r_green1) + 10'(r_blue1);
    assign avg_prod1 = 20'(sum1) * 20'(AvgRecip);
    assign n_avg     = avg_prod1[AvgShift +: ChanW];

    logic [ChanW-1:0] r_red2, r_green2, r_blue2, r_alpha2, r_avg2;

    always_ff @(posedge i_clk) begin
        if (en2 && r_vld1) begin
            r_red2   <= r_red1;
            r_green2 <= r_green1;
            r_blue2  <= r_blue1;
            r_alpha2 <= r_alpha1;
            r_avg2   <= n_avg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: brightness level and per-channel blend avg*(256-s) + s*c
    // ---------------------------------------------------------------
    function automatic logic signed [19:0] blend(input logic [ChanW-1:0] avg,
                                                 input logic [ChanW-1:0] chan,
                                                 input logic signed [9:0] kp,
                                                 input logic [SatW-1:0] sat);
        logic signed [19:0] base;
        logic [16:0]        sc;
        base = $signed({12'd0, avg}) * 20'(kp);
        sc   = 17'(sat) * 17'(chan);
        return base + $signed({3'd0, sc});
    endfunction

    logic [17:0]      vc_prod2;
    logic [ChanW-1:0] n_vc;

    assign vc_prod2 = 18'(coef.gain) * 18'(r_avg2);
    assign n_vc     = (|vc_prod2[17:16]) ? 8'hFF : vc_prod2[15:8];

    logic [ChanW-1:0]   r_vc3, r_alpha3;
    logic signed [19:0] r_mix_red3, r_mix_green3, r_mix_blue3;

    always_ff @(posedge i_clk) begin
        if (en3 && r_vld2) begin
            r_vc3        <= n_vc;
            r_alpha3     <= r_alpha2;
            r_mix_red3   <= blend(r_avg2, r_red2,   coef.kp, coef.sat);
            r_mix_green3 <= blend(r_avg2, r_green2, coef.kp, coef.sat);
            r_mix_blue3  <= blend(r_avg2, r_blue2,  coef.kp, coef.sat);
        end
    end

    // ---------------------------------------------------------------
    // stage 4: numerators of p, q, t and of the hue-keeping channels
    // ---------------------------------------------------------------
    logic [ChanW-1:0]   r_vc4, r_alpha4;
    logic signed [19:0] r_num_p4;
    logic signed [28:0] r_num_q4, r_num_t4;
    logic signed [29:0] r_num_red4, r_num_green4, r_num_blue4;

    always_ff @(posedge i_clk) begin
        if (en4 && r_vld3) begin
            r_vc4        <= r_vc3;
            r_alpha4     <= r_alpha3;
            r_num_p4     <= $signed({12'd0, r_vc3}) * 20'(coef.kp);
            r_num_q4     <= $signed({21'd0, r_vc3}) * 29'(coef.kq);
            r_num_t4     <= $signed({21'd0, r_vc3}) * 29'(coef.kt);
            r_num_red4   <= $signed({20'd0, coef.gain}) * 30'(r_mix_red3);
            r_num_green4 <= $signed({20'd0, coef.gain}) * 30'(r_mix_green3);
            r_num_blue4  <= $signed({20'd0, coef.gain}) * 30'(r_mix_blue3);
        end
    end

    // ---------------------------------------------------------------
    // stage 5: divide, clamp to 0..255, pick mode and sector
    // ---------------------------------------------------------------
    // n / 256
    function automatic logic [ChanW-1:0] clamp_p(input logic signed [19:0] n);
        if (n <= 20'sd0)   return '0;
        if (|n[19:16])     return 8'hFF;
        return n[15:8];
    endfunction

    // n / 65536
    function automatic logic [ChanW-1:0] clamp_keep(input logic signed [29:0] n);
        if (n <= 30'sd0)   return '0;
        if (|n[29:24])     return 8'hFF;
        return n[23:16];
    endfunction

    // n / 245760 = ((n >> 14) / 15); positive n stays below 2^26
    function automatic logic [ChanW-1:0] clamp_frac(input logic signed [28:0] n);
        logic [11:0] y;
        logic [27:0] prod;
        logic [8:0]  q;
        y    = n[25:14];
        prod = 28'(y) * 28'(R15Recip);
        q    = prod[R15Shift +: 9];
        if (n <= 29'sd0) return '0;
        if (q[8])        return 8'hFF;
        return q[7:0];
    endfunction

    logic [ChanW-1:0] p5, q5, t5;
    logic [ChanW-1:0] n_red, n_green, n_blue;

    assign p5 = clamp_p(r_num_p4);
    assign q5 = clamp_frac(r_num_q4);
    assign t5 = clamp_frac(r_num_t4);

    always_comb begin
        n_red   = r_vc4;
        n_green = r_vc4;
        n_blue  = r_vc4;
        if (coef.sat == '0) begin
            // gray output wins over both hue modes
            n_red   = r_vc4;
        end else if (!coef.hue_keep) begin
            case (coef.sector)
                SECT_R_Y: begin n_red = r_vc4; n_green = t5;    n_blue = p5;    end
                SECT_Y_G: begin n_red = q5;    n_green = r_vc4; n_blue = p5;    end
                SECT_G_C: begin n_red = p5;    n_green = r_vc4; n_blue = t5;    end
                SECT_C_B: begin n_red = p5;    n_green = q5;    n_blue = r_vc4; end
                SECT_B_M: begin n_red = t5;    n_green = p5;    n_blue = r_vc4; end
                default:  begin n_red = r_vc4; n_green = p5;    n_blue = q5;    end
            endcase
        end else begin
            n_red   = clamp_keep(r_num_red4);
            n_green = clamp_keep(r_num_green4);
            n_blue  = clamp_keep(r_num_blue4);
        end
    end

    logic [ChanW-1:0] r_red5, r_green5, r_blue5, r_alpha5;

    always_ff @(posedge i_clk) begin
        if (en5 && r_vld4) begin
            r_red5   <= n_red;
            r_green5 <= n_green;
            r_blue5  <= n_blue;
            r_alpha5 <= r_alpha4;
        end
    end

    assign o_pix.valid     = r_vld5;
    assign o_pix.red_out   = r_red5;
    assign o_pix.green_out = r_green5;
    assign o_pix.blue_out  = r_blue5;
    assign o_pix.alpha_out = r_alpha5;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // input only backs up once every stage holds a pixel
    a_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_vld1 && r_vld2 && r_vld3 && r_vld4 && r_vld5))
        else $error("input stalled with an empty stage");

    // an empty output stage is filled from a waiting stage 4 beat
    a_bubble_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld5 && r_vld4) |=> r_vld5)
        else $error("output bubble not filled");

    // a stalled output keeps stage 4 occupied
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld5 && r_vld4 && !o_pix.ready) |=> (r_vld4 && r_vld5))
        else $error("beat dropped during output stall");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("output valid after reset");

endmodule

>>> rtl/hpt_cfg.sv
// Configuration registers and the hue coefficients derived from them.
`timescale 1ns / 1ps

module hpt_cfg
    import hpt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_coef               o_coef
);

    logic             r_hue_keep;
    logic [HueW-1:0]  r_hue;
    logic [SatW-1:0]  r_sat;
    logic [GainW-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_keep <= 1'b1;
            r_hue      <= '0;
            r_sat      <= SatW'(OneS);
            r_gain     <= GainW'(OneS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HUE_KEEP: r_hue_keep <= i_cfg_data[0];
                CFG_HUE:      r_hue      <= i_cfg_data[HueW-1:0];
                CFG_SAT:      r_sat      <= i_cfg_data[SatW-1:0];
                CFG_GAIN:     r_gain     <= i_cfg_data[GainW-1:0];
                default: ;
            endcase
        end
    end

    // sector and fraction of the set hue; out-of-range hue folds to zero
    logic [HueW-1:0]  h_eff;
    t_sector          sect;
    logic [FracW-1:0] frac;

    always_comb begin
        h_eff = (r_hue >= HueW'(HueFull)) ? '0 : r_hue;
        if (h_eff < HueW'(HueSector))          sect = SECT_R_Y;
        else if (h_eff < HueW'(2 * HueSector)) sect = SECT_Y_G;
        else if (h_eff < HueW'(3 * HueSector)) sect = SECT_G_C;
        else if (h_eff < HueW'(4 * HueSector)) sect = SECT_C_B;
        else if (h_eff < HueW'(5 * HueSector)) sect = SECT_B_M;
        else                                   sect = SECT_M_R;
        frac = FracW'(h_eff - ({10'd0, sect} * HueW'(HueSector)));
    end

    t_sector           r_sect;
    logic [FracW-1:0]  r_frac;
    logic signed [9:0] r_kp;

    always_ff @(posedge i_clk) begin
        r_sect <= sect;
        r_frac <= frac;
        r_kp   <= $signed(10'(OneS)) - $signed({1'b0, r_sat});
    end

    logic [18:0]        sf;
    logic [18:0]        sg;
    logic signed [19:0] r_kq;
    logic signed [19:0] r_kt;

    assign sf = 19'(r_sat) * 19'(r_frac);
    assign sg = 19'(r_sat) * 19'(FracW'(HueSector) - r_frac);

    always_ff @(posedge i_clk) begin
        r_kq <= $signed(20'(FracOne)) - $signed({1'b0, sf});
        r_kt <= $signed(20'(FracOne)) - $signed({1'b0, sg});
    end

    assign o_coef = '{hue_keep: r_hue_keep, sat: r_sat, gain: r_gain, sector: r_sect,
                      kp: r_kp, kq: r_kq, kt: r_kt};

endmodule

>>> test/hsv_pixel_tint_unit_tb.sv
// Self-checking bench for the HSV pixel tint unit: pixel beats against a built-in tint model.
`timescale 1ns / 1ps

module hsv_pixel_tint_unit_tb;
    import hpt_pkg::*;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
    } t_pix;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    hpt_in_if  pix_in_bus ();
    hpt_out_if pix_out_bus ();

    hsv_pixel_tint_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in_bus),
        .o_pix      (pix_out_bus)
    );

    // Shadow copy of the register file, as the block should hold it.
    logic             cur_keep;
    logic [HueW-1:0]  cur_hue;
    logic [SatW-1:0]  cur_sat;
    logic [GainW-1:0] cur_gain;

    t_pix pixel_queue [$];   // beats waiting to be driven
    t_pix tint_expect [$];   // tinted pixels owed by the block, oldest first

    int   mismatch_count = 0;
    logic in_taken = 1'b0;    // input beat accepted at the last rising edge
    int   gap_left = 0;       // idle slots before the next input beat
    int   stall_left = 0;     // cycles the output side still holds ready low
    logic steady = 1'b0;      // no source gaps, no sink stalls
    logic hold_sender = 1'b0; // sender holds back until the pipe is empty

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tint model
    // ------------------------------------------------------------------

    // Truncating divide: non-positive numerators give 0, quotients cap at 255.
    function automatic logic [7:0] div_sat(longint num, longint den);
        longint quo;
        if (num <= 0) return 8'd0;
        quo = num / den;
        return (quo > 255) ? 8'd255 : quo[7:0];
    endfunction

    function automatic t_pix tint_pixel(t_pix px);
        longint   r, g, b, s, v, avg, vc, h, f, base;
        longint   one_s, sect_w, hue_full, frac_one;
        logic [7:0] p, q, t, w;
        t_sector  sect;
        t_pix     res;
        one_s    = longint'(OneS);
        sect_w   = longint'(HueSector);
        hue_full = longint'(HueFull);
        frac_one = longint'(FracOne);
        r = longint'(px.red);
        g = longint'(px.green);
        b = longint'(px.blue);
        s = longint'(cur_sat);
        v = longint'(cur_gain);
        avg = (r + g + b) / 3;
        vc  = longint'(div_sat(v * avg, one_s));
        res.alpha = px.alpha;
        if (s == 0) begin
            // gray wins over either hue mode
            res.red   = vc[7:0];
            res.green = vc[7:0];
            res.blue  = vc[7:0];
        end else if (!cur_keep) begin
            h = longint'(cur_hue);
            if (h >= hue_full) h = 0;   // out-of-range hue folds to red
            sect = t_sector'(h / sect_w);
            f = h % sect_w;
            w = vc[7:0];
            p = div_sat(vc * (one_s - s), one_s);
            q = div_sat(vc * (frac_one - s * f), frac_one);
            t = div_sat(vc * (frac_one - s * (sect_w - f)), frac_one);
            case (sect)
                SECT_R_Y: begin res.red = w; res.green = t; res.blue = p; end
                SECT_Y_G: begin res.red = q; res.green = w; res.blue = p; end
                SECT_G_C: begin res.red = p; res.green = w; res.blue = t; end
                SECT_C_B: begin res.red = p; res.green = q; res.blue = w; end
                SECT_B_M: begin res.red = t; res.green = p; res.blue = w; end
                default: begin res.red = w; res.green = p; res.blue = q; end
            endcase
        end else begin
            // own hue: blend each channel toward the gray level, then scale
            base = avg * (one_s - s);
            res.red   = div_sat(v * (base + s * r), one_s * one_s);
            res.green = div_sat(v * (base + s * g), one_s * one_s);
            res.blue  = div_sat(v * (base + s * b), one_s * one_s);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Idle run length: mostly none, some short, a few long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Channel value leaning a little toward the rails.
    function automatic logic [7:0] rand_chan();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Input driver: new beat only once the previous one was taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_pix nxt;
        if (!i_rst_n) begin
            pix_in_bus.valid <= 1'b0;
        end else if (pix_in_bus.valid && !in_taken) begin
            // beat still on the bus, hold it
        end else if (gap_left > 0 && !steady) begin
            pix_in_bus.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (hold_sender || pixel_queue.size() == 0) begin
            pix_in_bus.valid <= 1'b0;
        end else begin
            nxt = pixel_queue.pop_front();
            pix_in_bus.red_in   <= nxt.red;
            pix_in_bus.green_in <= nxt.green;
            pix_in_bus.blue_in  <= nxt.blue;
            pix_in_bus.alpha_in <= nxt.alpha;
            pix_in_bus.valid    <= 1'b1;
            gap_left <= idle_len();
        end
    end

    // Output back-pressure: random stalls, none in steady phases.
    always @(negedge i_clk) begin
        if (steady) begin
            pix_out_bus.ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            pix_out_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            pix_out_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left <= idle_len();
        end
    end

    task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: record accepted input beats, check output beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pix want;
        t_pix got;
        in_taken <= pix_in_bus.valid && pix_in_bus.ready;
        if (pix_in_bus.valid && pix_in_bus.ready)
            tint_expect.push_back(tint_pixel({pix_in_bus.red_in, pix_in_bus.green_in,
                                              pix_in_bus.blue_in, pix_in_bus.alpha_in}));
        if (pix_out_bus.valid && pix_out_bus.ready) begin
            got = {pix_out_bus.red_out, pix_out_bus.green_out,
                   pix_out_bus.blue_out, pix_out_bus.alpha_out};
            if (tint_expect.size() == 0) begin
                $display("%0t: unexpected output beat, expected none, got %h", $time, got);
                mismatch_count++;
            end else begin
                want = tint_expect.pop_front();
                check_chan("red", want.red, got.red);
                check_chan("green", want.green, got.green);
                check_chan("blue", want.blue, got.blue);
                check_chan("alpha", want.alpha, got.alpha);
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes (pipe must be empty)
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // bits above each register's width are dropped, spare indexes do nothing
        case (idx)
            CFG_HUE_KEEP: cur_keep = data[0];
            CFG_HUE:      cur_hue  = data[HueW-1:0];
            CFG_SAT:      cur_sat  = data[SatW-1:0];
            CFG_GAIN:     cur_gain = data[GainW-1:0];
            default: ;
        endcase
    endtask

    // Writes all four registers with junk in the unused upper bits, sometimes
    // followed by a write to a spare index.
    task automatic set_cfg(logic keep, logic [HueW-1:0] hue, logic [SatW-1:0] sat,
                           logic [GainW-1:0] gain);
        logic [CfgDataW-1:0] data;
        logic [CfgIdxW-1:0]  spare;
        data = CfgDataW'($urandom);
        data[0] = keep;
        write_reg(CFG_HUE_KEEP, data);
        write_reg(CFG_HUE, hue);
        data = CfgDataW'($urandom);
        data[SatW-1:0] = sat;
        write_reg(CFG_SAT, data);
        data = CfgDataW'($urandom);
        data[GainW-1:0] = gain;
        write_reg(CFG_GAIN, data);
        if ($urandom_range(0, 1)) begin
            spare = CfgIdxW'(CFG_GAIN + 1 + $urandom_range(0, 3));
            write_reg(spare, CfgDataW'($urandom));
        end
    endtask

    // Wait until every beat is out and the last result has been checked.
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || pix_in_bus.valid || tint_expect.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        pixel_queue.push_back({r, g, b, a});
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [HueW-1:0]  hue_pick [8];
        logic [HueW-1:0]  hue;
        logic [SatW-1:0]  sat;
        logic [GainW-1:0] gain;
        logic             keep;
        int               sel;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_HUE_KEEP;
        i_cfg_data = '0;
        pix_in_bus.valid    = 1'b0;
        pix_in_bus.red_in   = '0;
        pix_in_bus.green_in = '0;
        pix_in_bus.blue_in  = '0;
        pix_in_bus.alpha_in = '0;
        pix_out_bus.ready   = 1'b0;
        // reset values of the register file
        cur_keep = 1'b1;
        cur_hue  = '0;
        cur_sat  = 9'd256;
        cur_gain = 10'd256;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // --- directed: reset settings, channel extremes and alpha pass-through
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0);
        push_pixel(8'd0,   8'd255, 8'd0,   8'd255);
        push_pixel(8'd0,   8'd0,   8'd255, 8'h5A);
        push_pixel(8'd1,   8'd2,   8'd3,   8'hA5);
        wait_idle();

        // full gain with gray output: saturation zero with own hue
        set_cfg(1'b1, '0, 9'd0, 10'd1023);
        push_pixel(8'd255, 8'd128, 8'd7, 8'h3C);
        push_pixel(8'd40,  8'd90,  8'd200, 8'hC3);
        wait_idle();

        // gray takes precedence over a forced hue too
        set_cfg(1'b0, 13'd2000, 9'd0, 10'd300);
        push_pixel(8'd200, 8'd100, 8'd50, 8'h81);
        wait_idle();

        // one pixel per hue sector, the last hue value, and a hue out of range
        hue_pick = '{13'd0, 13'd1000, 13'd2000, 13'd3000, 13'd4000, 13'd5000,
                     13'd5759, 13'h1FFF};
        foreach (hue_pick[k]) begin
            set_cfg(1'b0, hue_pick[k], 9'd256, 10'd256);
            push_pixel(8'd200, 8'd100, 8'd50, 8'h7E);
            wait_idle();
        end

        // saturation above one: blend goes negative and must clamp at both ends
        set_cfg(1'b1, '0, 9'd511, 10'd1023);
        push_pixel(8'd255, 8'd0, 8'd10, 8'h11);
        push_pixel(8'd0, 8'd255, 8'd128, 8'hEE);
        wait_idle();
        set_cfg(1'b0, 13'd480, 9'd511, 10'd512);
        push_pixel(8'd180, 8'd60, 8'd240, 8'h42);
        wait_idle();

        // --- random phases
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_cfg(1'b1, '0,       9'd256, 10'd1023);
                1: set_cfg(1'b0, 13'd5759, 9'd511, 10'd1023);
                2: set_cfg(1'b0, 13'd0,    9'd1,   10'd0);
                3: set_cfg(1'b1, 13'd960,  9'd511, 10'd1);
                4: set_cfg(1'b1, 13'd4800, 9'd0,   10'd1023);
                5: set_cfg(1'b0, 13'h1FFF, 9'd256, 10'd255);
                default: begin
                    keep = 1'($urandom_range(0, 1));
                    sel = $urandom_range(0, 3);
                    if (sel == 0)      hue = HueW'(HueSector * $urandom_range(0, 5));
                    else if (sel == 1) hue = HueW'(HueSector * $urandom_range(1, 6) - 1);
                    else               hue = HueW'($urandom_range(0, 8191));
                    sel = $urandom_range(0, 9);
                    case (sel)
                        0: sat = 9'd0;
                        1: sat = 9'd256;
                        2: sat = 9'd511;
                        3: sat = SatW'($urandom_range(257, 511));
                        default: sat = SatW'($urandom_range(1, 256));
                    endcase
                    gain = ($urandom_range(0, 4) == 0) ? 10'd1023
                                                       : GainW'($urandom_range(0, 1023));
                    set_cfg(keep, hue, sat, gain);
                end
            endcase

            steady = (ph == 7);
            for (int n = 0; n < 85; n++)
                push_pixel(rand_chan(), rand_chan(), rand_chan(), 8'($urandom_range(0, 255)));

            if (ph == 8) begin
                // sender pauses mid-phase until the pipe has fully drained
                while (pixel_queue.size() > 40) @(posedge i_clk);
                hold_sender = 1'b1;
                while (pix_in_bus.valid || tint_expect.size() != 0) @(posedge i_clk);
                repeat (3) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_idle();
            steady = 1'b0;
        end

        // a final look for stray output beats after the pipe is empty
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
